// File: sv/tcc_pkg.sv
package tcc_pkg;

  localparam int COLUMNS_DEF    = 80;
  localparam int ROWS_DEF       = 25;
  localparam int POST_CELLS_DEF = 2;

  localparam int OPCODE_W = 2;
  localparam int VALUE_W  = 8;
  localparam int CELL_W   = 11;
  localparam int CHAR_W   = 8;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_BSPACE  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_BLANK   = 8'h20;

  localparam logic [3:0] TAB_STOP = 4'd8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT  = 2'd0,
    OP_POST = 2'd1,
    OP_READ = 2'd2,
    OP_LOAD = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUT,
    ST_NEWLINE,
    ST_CHECK,
    ST_PRIME,
    ST_SCROLL,
    ST_POST_LO,
    ST_READ,
    ST_DONE
  } state_e;

  function automatic logic [CHAR_W-1:0] hex_ascii(input logic [3:0] nib);
    logic [CHAR_W-1:0] ext;
    ext = {4'h0, nib};
    if (nib < 4'd10) begin
      return 8'h30 + ext;
    end
    return 8'h37 + ext;
  endfunction

endpackage

// File: sv/tcc_cmd_if.sv
interface tcc_cmd_if import tcc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [VALUE_W-1:0]  value;
  logic [CELL_W-1:0]   cell_address;
  logic                last_of_string;

  modport source (output valid, opcode, value, cell_address, last_of_string, input ready);
  modport sink   (input valid, opcode, value, cell_address, last_of_string, output ready);
endinterface

// File: sv/tcc_rsp_if.sv
interface tcc_rsp_if import tcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cursor_cell;
  logic [CHAR_W-1:0] read_char;
  logic              scrolled;

  modport source (output valid, cursor_cell, read_char, scrolled, input ready);
  modport sink   (input valid, cursor_cell, read_char, scrolled, output ready);
endinterface

// File: sv/text_console_cursor_engine.sv
// Text console with a COLUMNS x ROWS character store in a single-write, single-read memory
// and a cursor; one command word in, one response word out. After reset a clearing pass
// writes spaces to all COLUMNS*ROWS cells, one per cycle, before the first command is taken.
// A plain character is written, bound-checked and then answered; a tab writes and checks
// blanks one at a time (up to 8); a backspace, load or post goes straight to the response
// once its writes are done; a read waits for the memory output; a newline finds the row
// start by repeated add of COLUMNS. Any put that reaches the post-code cells adds a scroll
// walk, one cell per cycle, since the store has one write and one read port.
// The next command is taken while a finished response still waits in the output register.
module text_console_cursor_engine import tcc_pkg::*; #(
  parameter int COLUMNS    = COLUMNS_DEF,
  parameter int ROWS       = ROWS_DEF,
  parameter int POST_CELLS = POST_CELLS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  tcc_cmd_if.sink   cmd_i,
  tcc_rsp_if.source rsp_o
);

  localparam int SC    = COLUMNS * ROWS;
  localparam int LIMIT = SC - POST_CELLS;
  localparam int BSTRT = COLUMNS * (ROWS - 1) - POST_CELLS;
  localparam int AW    = $clog2(SC);
  localparam int CW    = $clog2(SC + 1);

  localparam logic [CW-1:0] LIMIT_C = CW'(LIMIT);
  localparam logic [CW-1:0] COL_C   = CW'(COLUMNS);
  localparam logic [CW-1:0] LAST_C  = CW'(SC - 1);
  localparam logic [CW-1:0] WLAST_C = CW'(LIMIT - 1);
  localparam logic [CW-1:0] BSTRT_C = CW'(BSTRT);
  localparam logic [CW:0]   SC_X    = (CW+1)'(SC);
  localparam logic [CW:0]   RDOFS_X = (CW+1)'(COLUMNS + 1);

  state_e            state_q, state_d;
  logic [CW-1:0]     cursor_q, cursor_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [3:0]        n_q, n_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic              scrolled_q, scrolled_d;
  logic              rd_hit_q, rd_hit_d;
  logic [CHAR_W-1:0] rd_char_q, rd_char_d;

  logic              out_valid_q, out_valid_d;
  logic [CW-1:0]     out_cursor_q, out_cursor_d;
  logic [CHAR_W-1:0] out_char_q, out_char_d;
  logic              out_scrolled_q, out_scrolled_d;

  logic [CHAR_W-1:0] screen_mem [SC];
  logic [CHAR_W-1:0] mem_rd_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_wa, mem_ra;
  logic [CHAR_W-1:0] mem_wd;

  logic [CW:0]       nl_sum;
  logic [CW:0]       scr_ra;
  logic [CW-1:0]     bs_cell;
  logic              addr_in_range;
  logic              addr_over;

  always_comb begin
    nl_sum        = {1'b0, idx_q} + {1'b0, COL_C};
    scr_ra        = {1'b0, idx_q} + RDOFS_X;
    bs_cell       = (cursor_q != '0) ? cursor_q - CW'(1) : '0;
    addr_in_range = 32'(cmd_i.cell_address) < 32'(SC);
    addr_over     = 32'(cmd_i.cell_address) > 32'(LIMIT - 1);
  end

  always_comb begin
    state_d        = state_q;
    cursor_d       = cursor_q;
    idx_d          = idx_q;
    n_d            = n_q;
    char_d         = char_q;
    scrolled_d     = scrolled_q;
    rd_hit_d       = rd_hit_q;
    rd_char_d      = rd_char_q;
    out_valid_d    = out_valid_q && !rsp_o.ready;
    out_cursor_d   = out_cursor_q;
    out_char_d     = out_char_q;
    out_scrolled_d = out_scrolled_q;
    mem_we         = 1'b0;
    mem_wa         = cursor_q[AW-1:0];
    mem_wd         = CH_BLANK;
    mem_re         = 1'b0;
    mem_ra         = cmd_i.cell_address[AW-1:0];
    cmd_i.ready    = (state_q == ST_IDLE);

    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = idx_q[AW-1:0];
        if (idx_q == LAST_C) begin
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      ST_IDLE: begin
        if (cmd_i.valid) begin
          scrolled_d = 1'b0;
          rd_char_d  = '0;
          n_d        = '0;
          unique case (op_e'(cmd_i.opcode))
            OP_PUT: begin
              if (cmd_i.value == CH_NEWLINE) begin
                idx_d   = '0;
                state_d = ST_NEWLINE;
              end else if (cmd_i.value == CH_TAB) begin
                char_d  = CH_BLANK;
                n_d     = TAB_STOP - {1'b0, cursor_q[2:0]};
                state_d = ST_PUT;
              end else if (cmd_i.value == CH_BSPACE) begin
                mem_we   = 1'b1;
                mem_wa   = bs_cell[AW-1:0];
                cursor_d = bs_cell;
                state_d  = ST_DONE;
              end else begin
                char_d  = cmd_i.value;
                n_d     = 4'd1;
                state_d = ST_PUT;
              end
            end
            OP_POST: begin
              mem_we  = 1'b1;
              mem_wa  = AW'(SC - 2);
              mem_wd  = hex_ascii(cmd_i.value[7:4]);
              char_d  = cmd_i.value;
              state_d = ST_POST_LO;
            end
            OP_READ: begin
              mem_re   = addr_in_range;
              rd_hit_d = addr_in_range;
              state_d  = ST_READ;
            end
            OP_LOAD: begin
              cursor_d = addr_over ? WLAST_C : CW'(cmd_i.cell_address);
              state_d  = ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_PUT: begin
        mem_we   = (cursor_q < CW'(SC));
        mem_wd   = char_q;
        cursor_d = cursor_q + CW'(1);
        n_d      = n_q - 4'd1;
        state_d  = ST_CHECK;
      end
      ST_NEWLINE: begin
        if (nl_sum <= {1'b0, cursor_q}) begin
          idx_d = nl_sum[CW-1:0];
        end else begin
          cursor_d = nl_sum[CW-1:0];
          state_d  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (cursor_q >= LIMIT_C) begin
          cursor_d   = cursor_q - COL_C;
          scrolled_d = 1'b1;
          idx_d      = '0;
          state_d    = ST_PRIME;
        end else if (n_q != '0) begin
          state_d = ST_PUT;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_PRIME: begin
        mem_re  = 1'b1;
        mem_ra  = AW'(COLUMNS);
        state_d = ST_SCROLL;
      end
      ST_SCROLL: begin
        mem_we = 1'b1;
        mem_wa = idx_q[AW-1:0];
        mem_wd = (idx_q >= BSTRT_C) ? CH_BLANK : mem_rd_q;
        mem_re = (scr_ra < SC_X);
        mem_ra = scr_ra[AW-1:0];
        if (idx_q == WLAST_C) begin
          state_d = ST_CHECK;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      ST_POST_LO: begin
        mem_we  = 1'b1;
        mem_wa  = AW'(SC - 1);
        mem_wd  = hex_ascii(char_q[3:0]);
        state_d = ST_DONE;
      end
      ST_READ: begin
        rd_char_d = rd_hit_q ? mem_rd_q : '0;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d    = 1'b1;
          out_cursor_d   = cursor_q;
          out_char_d     = rd_char_q;
          out_scrolled_d = scrolled_q;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cursor_q    <= '0;
      idx_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q         <= char_d;
    scrolled_q     <= scrolled_d;
    rd_hit_q       <= rd_hit_d;
    rd_char_q      <= rd_char_d;
    out_cursor_q   <= out_cursor_d;
    out_char_q     <= out_char_d;
    out_scrolled_q <= out_scrolled_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_q <= screen_mem[mem_ra];
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.cursor_cell = CELL_W'(out_cursor_q);
  assign rsp_o.read_char   = out_char_q;
  assign rsp_o.scrolled    = out_scrolled_q;

endmodule

// File: sv/tcc_checker.sv
module tcc_checker import tcc_pkg::*; #(
  parameter int COLUMNS    = COLUMNS_DEF,
  parameter int ROWS       = ROWS_DEF,
  parameter int POST_CELLS = POST_CELLS_DEF
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cmd_valid_i,
  input logic              cmd_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [CELL_W-1:0] rsp_cursor_i,
  input logic [CHAR_W-1:0] rsp_char_i,
  input logic              rsp_scrolled_i
);

  localparam int LIMIT = COLUMNS * ROWS - POST_CELLS;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_cursor_i)
      && $stable(rsp_char_i) && $stable(rsp_scrolled_i))
    else $error("response word changed while stalled");

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> 32'(rsp_cursor_i) < 32'(LIMIT))
    else $error("cursor reached post-code cells");

  a_read_no_scroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_char_i != '0) |-> !rsp_scrolled_i)
    else $error("read word reports a scroll");

  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("command word taken while previous one still in work");

endmodule

bind text_console_cursor_engine tcc_checker #(
  .COLUMNS    (COLUMNS),
  .ROWS       (ROWS),
  .POST_CELLS (POST_CELLS)
) u_tcc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cmd_valid_i    (cmd_i.valid),
  .cmd_ready_i    (cmd_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_cursor_i   (rsp_o.cursor_cell),
  .rsp_char_i     (rsp_o.read_char),
  .rsp_scrolled_i (rsp_o.scrolled)
);

// File: tb/text_console_cursor_engine_test.sv
module text_console_cursor_engine_test;
  import tcc_pkg::*;

  localparam int COLUMNS      = COLUMNS_DEF;
  localparam int ROWS         = ROWS_DEF;
  localparam int POST_CELLS   = POST_CELLS_DEF;
  localparam int CELLS        = COLUMNS * ROWS;
  localparam int SCROLL_AT    = CELLS - POST_CELLS;
  localparam int BLANK_FROM   = COLUMNS * (ROWS - 1) - POST_CELLS;
  localparam int QUIET_LIMIT  = 20000;
  localparam int WORD_TARGET  = 875;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 500;
  localparam int DRAIN_CYCLES = 100;

  localparam logic [CHAR_W-1:0] DIGIT_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] DIGIT_TEN  = 8'h41;

  typedef struct packed {
    logic [CELL_W-1:0] cursor_cell;
    logic [CHAR_W-1:0] read_char;
    logic              scrolled;
  } console_reply_t;

  class console_shadow;
    logic [CHAR_W-1:0] screen [CELLS];
    int unsigned       cursor;
    console_reply_t    replies_due [$];
    int unsigned       op_count [4];
    int unsigned       scrolls_seen;
    int unsigned       mismatches;

    function new();
      foreach (screen[i]) screen[i] = CH_BLANK;
      cursor = 0;
      foreach (op_count[i]) op_count[i] = 0;
      scrolls_seen = 0;
      mismatches = 0;
    endfunction

    function logic [CHAR_W-1:0] hex_digit(logic [3:0] nib);
      if (nib < 4'd10) begin
        return DIGIT_ZERO + CHAR_W'(nib);
      end
      return DIGIT_TEN + CHAR_W'(nib) - CHAR_W'(10);
    endfunction

    function bit scroll_up();
      if (cursor < SCROLL_AT) begin
        return 1'b0;
      end
      for (int i = 0; i < COLUMNS * (ROWS - 1); i++) screen[i] = screen[i + COLUMNS];
      for (int i = 0; i < COLUMNS; i++) screen[BLANK_FROM + i] = CH_BLANK;
      cursor -= COLUMNS;
      return 1'b1;
    endfunction

    function bit put_blank();
      if (cursor < CELLS) screen[cursor] = CH_BLANK;
      cursor++;
      return scroll_up();
    endfunction

    function void note_command(op_e op, logic [CHAR_W-1:0] val, logic [CELL_W-1:0] addr);
      console_reply_t r;
      int unsigned    n;
      r = '0;
      op_count[op]++;
      case (op)
        OP_PUT: begin
          if (val == CH_NEWLINE) begin
            cursor = (cursor / COLUMNS + 1) * COLUMNS;
          end else if (val == CH_TAB) begin
            n = TAB_STOP - (cursor % TAB_STOP);
            repeat (n) if (put_blank()) r.scrolled = 1'b1;
          end else if (val == CH_BSPACE) begin
            if (cursor >= 1) cursor--;
            r.scrolled = put_blank();
            if (cursor >= 1) cursor--;
          end else begin
            if (cursor < CELLS) screen[cursor] = val;
            cursor++;
          end
          if (scroll_up()) r.scrolled = 1'b1;
        end
        OP_POST: begin
          screen[CELLS-2] = hex_digit(val[7:4]);
          screen[CELLS-1] = hex_digit(val[3:0]);
        end
        OP_READ: begin
          if (addr < CELLS) r.read_char = screen[addr];
        end
        OP_LOAD: begin
          cursor = (addr > SCROLL_AT - 1) ? SCROLL_AT - 1 : addr;
        end
        default: ;
      endcase
      r.cursor_cell = CELL_W'(cursor);
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic [CELL_W-1:0] cur, logic [CHAR_W-1:0] rd, logic sc);
      console_reply_t want;
      if (replies_due.size() == 0) begin
        $error("reply word with nothing outstanding: cursor_cell %0d read_char %02h scrolled %0b",
               cur, rd, sc);
        mismatches++;
        return;
      end
      want = replies_due.pop_front();
      if (cur !== want.cursor_cell) begin
        $error("cursor_cell expected %0d actual %0d", want.cursor_cell, cur);
        mismatches++;
      end
      if (rd !== want.read_char) begin
        $error("read_char expected %02h actual %02h", want.read_char, rd);
        mismatches++;
      end
      if (sc !== want.scrolled) begin
        $error("scrolled expected %0b actual %0b", want.scrolled, sc);
        mismatches++;
      end
      if (want.scrolled) scrolls_seen++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  tcc_cmd_if cmd ();
  tcc_rsp_if rsp ();

  text_console_cursor_engine #(
    .COLUMNS    (COLUMNS),
    .ROWS       (ROWS),
    .POST_CELLS (POST_CELLS)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rsp_o  (rsp)
  );

  console_shadow board;
  bit            steady;
  int unsigned   words_sent;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned pause_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic send_command(input op_e op, input logic [VALUE_W-1:0] val,
                              input logic [CELL_W-1:0] addr, input logic last);
    int unsigned gap;
    gap = steady ? 0 : pause_len();
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd.valid          <= 1'b1;
    cmd.opcode         <= op;
    cmd.value          <= val;
    cmd.cell_address   <= addr;
    cmd.last_of_string <= last;
    @(posedge clk_i);
    while (!cmd.ready) @(posedge clk_i);
    words_sent++;
  endtask

  always @(posedge clk_i) begin
    if (cmd.valid && cmd.ready) begin
      board.note_command(op_e'(cmd.opcode), cmd.value, cmd.cell_address);
    end
    if (rsp.valid && rsp.ready) begin
      board.check_reply(rsp.cursor_cell, rsp.read_char, rsp.scrolled);
    end
  end

  initial begin
    bit          held;
    int unsigned n;
    held = 1'b0;
    rsp.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!held && words_sent >= HOLD_AFTER) begin
        held = 1'b1;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        n = steady ? 0 : pause_len();
        if (n > 0) begin
          rsp.ready <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
      end
      rsp.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) quiet = 0;
      else quiet++;
    end
    $display("text_console_cursor_engine test failed");
    $finish;
  end

  initial begin
    int unsigned       pick;
    int unsigned       len;
    int unsigned       near;
    logic [CHAR_W-1:0] ch;
    logic [CELL_W-1:0] addr;
    board = new();
    steady = 1'b0;
    words_sent = 0;
    rst_ni = 1'b0;
    cmd.valid = 1'b0;
    cmd.opcode = OP_PUT;
    cmd.value = '0;
    cmd.cell_address = '0;
    cmd.last_of_string = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_command(OP_READ, 8'h00, 11'd0,    1'b0);
    send_command(OP_READ, 8'hff, 11'd1999, 1'b1);
    send_command(OP_READ, 8'h00, 11'd2000, 1'b0);
    send_command(OP_READ, 8'h00, 11'd2047, 1'b0);
    send_command(OP_PUT,  8'h41, 11'd0,    1'b0);
    send_command(OP_PUT,  8'hff, 11'd2047, 1'b0);
    send_command(OP_PUT,  8'h00, 11'd0,    1'b0);
    send_command(OP_PUT,  CH_TAB,     11'd0, 1'b0);
    send_command(OP_PUT,  CH_BSPACE,  11'd0, 1'b0);
    send_command(OP_PUT,  CH_NEWLINE, 11'd0, 1'b0);
    send_command(OP_PUT,  CH_BSPACE,  11'd0, 1'b1);
    send_command(OP_LOAD, 8'h00, 11'd0,    1'b0);
    send_command(OP_PUT,  CH_BSPACE,  11'd0, 1'b1);
    send_command(OP_POST, 8'h00, 11'd0,    1'b0);
    send_command(OP_POST, 8'hff, 11'd0,    1'b0);
    send_command(OP_POST, 8'ha5, 11'd0,    1'b0);
    send_command(OP_READ, 8'h00, 11'd1998, 1'b0);
    send_command(OP_READ, 8'h00, 11'd1999, 1'b0);
    send_command(OP_LOAD, 8'h00, 11'd2047, 1'b0);
    send_command(OP_PUT,  8'h7a, 11'd0,    1'b1);
    send_command(OP_READ, 8'h00, 11'd1917, 1'b0);
    send_command(OP_LOAD, 8'h00, 11'd1993, 1'b0);
    send_command(OP_PUT,  CH_TAB,     11'd0, 1'b1);
    send_command(OP_LOAD, 8'h00, 11'd1950, 1'b0);
    send_command(OP_PUT,  CH_NEWLINE, 11'd0, 1'b1);
    send_command(OP_READ, 8'h00, 11'd1919, 1'b0);

    while (words_sent < WORD_TARGET) begin
      if ($urandom_range(0, 39) == 0) steady = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 70)      ch = CHAR_W'($urandom_range(8'h20, 8'h7e));
          else if (pick < 78) ch = CH_NEWLINE;
          else if (pick < 84) ch = CH_TAB;
          else if (pick < 90) ch = CH_BSPACE;
          else                ch = CHAR_W'($urandom_range(0, 255));
          send_command(OP_PUT, ch, CELL_W'($urandom_range(0, 2047)), k == len - 1);
        end
      end else if (pick < 72) begin
        near = board.cursor;
        pick = $urandom_range(0, 99);
        if (pick < 10)      addr = CELL_W'($urandom_range(0, 2047));
        else if (pick < 16) addr = CELL_W'($urandom_range(CELLS - POST_CELLS, CELLS - 1));
        else if (near > 200) addr = CELL_W'(near - $urandom_range(0, 200));
        else                addr = CELL_W'($urandom_range(0, CELLS - 1));
        send_command(OP_READ, VALUE_W'($urandom_range(0, 255)), addr,
                     1'($urandom_range(0, 1)));
      end else if (pick < 88) begin
        pick = $urandom_range(0, 99);
        if (pick < 50)      addr = CELL_W'($urandom_range(1900, SCROLL_AT - 1));
        else if (pick < 90) addr = CELL_W'($urandom_range(0, 2047));
        else                addr = CELL_W'($urandom_range(SCROLL_AT, 2047));
        send_command(OP_LOAD, VALUE_W'($urandom_range(0, 255)), addr,
                     1'($urandom_range(0, 1)));
      end else begin
        send_command(OP_POST, VALUE_W'($urandom_range(0, 255)),
                     CELL_W'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)));
      end
    end
    cmd.valid <= 1'b0;

    while (board.replies_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d command words: %0d put, %0d post, %0d read, %0d load",
             words_sent, board.op_count[OP_PUT], board.op_count[OP_POST],
             board.op_count[OP_READ], board.op_count[OP_LOAD]);
    $display("%0d replies reported a scroll, %0d field mismatches",
             board.scrolls_seen, board.mismatches);
    if (board.mismatches == 0) begin
      $display("text_console_cursor_engine test passed");
    end else begin
      $display("text_console_cursor_engine test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/tcc_pkg.sv
sv/tcc_cmd_if.sv
sv/tcc_rsp_if.sv
sv/text_console_cursor_engine.sv
sv/tcc_checker.sv
tb/text_console_cursor_engine_test.sv
